@@ rtl/xdfd_pkg.sv @@
// ----------------------------------------------------------------------------
// xdfd_pkg
// Types and constants shared by the delta frame decoder modules.
// ----------------------------------------------------------------------------
package xdfd_pkg;

  localparam logic [1:0] ACT_DELTA   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;
  localparam logic [1:0] ACT_IDLE    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [1:0] REG_ROW_STRIDE  = 2'd1;
  localparam logic [1:0] REG_COPY_MODE   = 2'd2;
  localparam logic [1:0] REG_FRAME_LIMIT = 2'd3;

  localparam logic       DO_XOR      = 1'b0;
  localparam logic [7:0] WORD_ESCAPE = 8'd128;
  localparam logic [16:0] POS_MAX    = 17'h1FFFF;

  typedef enum logic [2:0] {
    PH_OPCODE, PH_SRUN_COUNT, PH_SRUN_VALUE, PH_WORD_LO, PH_WORD_HI, PH_DUMP, PH_LRUN_VALUE
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_CLEAR, BK_ADV, BK_WRITE, BK_RMW, BK_READ, BK_DONE, BK_NORM
  } back_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  delta_byte;
    logic [15:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  status;
    logic [15:0] bytes_used;
  } out_item_t;

  // work command from front to back
  typedef enum logic [2:0] {
    CMD_NONE, CMD_ADVANCE, CMD_WRITE, CMD_RUN, CMD_READ, CMD_END, CMD_RESTART, CMD_CHECK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] count;
    logic [7:0]  value;
    logic [15:0] addr;
    logic [15:0] used;
  } cmd_t;

endpackage

@@ rtl/xdfd_front.sv @@
// ----------------------------------------------------------------------------
// xdfd_front
// Parses the delta byte stream into position, write, limit-check and end commands,
// and passes reads and restarts through.
module xdfd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  xdfd_pkg::in_item_t item,
  input  logic               err,
  output xdfd_pkg::cmd_t     cmd
);

  xdfd_pkg::phase_t phase, phase_next;
  logic [14:0] op_count, op_count_next;
  logic [7:0]  word_low_byte, word_low_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [15:0] word;
  logic [15:0] cnt_inc;

  always_comb begin
    cnt_inc = (byte_counter != 16'hFFFF) ? byte_counter + 16'd1 : byte_counter;
    word = {item.delta_byte, word_low_byte};
    phase_next = phase;
    op_count_next = op_count;
    word_low_next = word_low_byte;
    byte_counter_next = byte_counter;
    cmd = '0;
    cmd.kind = xdfd_pkg::CMD_NONE;
    cmd.addr = item.read_address;
    cmd.value = item.delta_byte;
    if (take) begin
      unique case (item.action)
        xdfd_pkg::ACT_READ: cmd.kind = xdfd_pkg::CMD_READ;
        xdfd_pkg::ACT_RESTART: begin
          cmd.kind = xdfd_pkg::CMD_RESTART;
          phase_next = xdfd_pkg::PH_OPCODE;
          op_count_next = '0;
          word_low_next = '0;
          byte_counter_next = '0;
        end
        xdfd_pkg::ACT_IDLE: cmd.kind = xdfd_pkg::CMD_NONE;
        xdfd_pkg::ACT_DELTA: begin
          if (!err) begin
            byte_counter_next = cnt_inc;
            unique case (phase)
              xdfd_pkg::PH_OPCODE: begin
                if (item.delta_byte == 8'd0) begin
                  phase_next = xdfd_pkg::PH_SRUN_COUNT;
                end else if (item.delta_byte < xdfd_pkg::WORD_ESCAPE) begin
                  // dump: limit check only, the data bytes follow
                  cmd.kind = xdfd_pkg::CMD_CHECK;
                  cmd.count = {8'd0, item.delta_byte};
                  op_count_next = {7'd0, item.delta_byte};
                  phase_next = xdfd_pkg::PH_DUMP;
                end else if (item.delta_byte == xdfd_pkg::WORD_ESCAPE) begin
                  phase_next = xdfd_pkg::PH_WORD_LO;
                end else begin
                  cmd.kind = xdfd_pkg::CMD_ADVANCE;
                  cmd.count = {9'd0, item.delta_byte[6:0]};
                end
              end
              xdfd_pkg::PH_SRUN_COUNT: begin
                op_count_next = {7'd0, item.delta_byte};
                phase_next = xdfd_pkg::PH_SRUN_VALUE;
              end
              xdfd_pkg::PH_SRUN_VALUE, xdfd_pkg::PH_LRUN_VALUE: begin
                phase_next = xdfd_pkg::PH_OPCODE;
                cmd.kind = xdfd_pkg::CMD_RUN;
                cmd.count = {1'b0, op_count};
              end
              xdfd_pkg::PH_WORD_LO: begin
                word_low_next = item.delta_byte;
                phase_next = xdfd_pkg::PH_WORD_HI;
              end
              xdfd_pkg::PH_WORD_HI: begin
                phase_next = xdfd_pkg::PH_OPCODE;
                if (word == 16'd0) begin
                  cmd.kind = xdfd_pkg::CMD_END;
                  cmd.used = cnt_inc;
                  phase_next = xdfd_pkg::PH_OPCODE;
                  op_count_next = '0;
                  word_low_next = '0;
                  byte_counter_next = '0;
                end else if (!word[15]) begin
                  cmd.kind = xdfd_pkg::CMD_ADVANCE;
                  cmd.count = word;
                end else if (!word[14]) begin
                  // the limit is checked even for an empty dump
                  op_count_next = word[14:0];
                  cmd.kind = xdfd_pkg::CMD_CHECK;
                  cmd.count = {2'd0, word[13:0]};
                  if (word[13:0] != 14'd0) phase_next = xdfd_pkg::PH_DUMP;
                end else begin
                  op_count_next = {1'b0, word[13:0]};
                  phase_next = xdfd_pkg::PH_LRUN_VALUE;
                end
              end
              xdfd_pkg::PH_DUMP: begin
                cmd.kind = xdfd_pkg::CMD_WRITE;
                cmd.count = 16'd1;
                op_count_next = op_count - 15'd1;
                if (op_count == 15'd1) phase_next = xdfd_pkg::PH_OPCODE;
              end
              default: phase_next = xdfd_pkg::PH_OPCODE;
            endcase
          end
        end
        default: cmd.kind = xdfd_pkg::CMD_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= xdfd_pkg::PH_OPCODE;
      op_count <= '0;
      word_low_byte <= '0;
      byte_counter <= '0;
    end else begin
      phase <= phase_next;
      op_count <= op_count_next;
      word_low_byte <= word_low_next;
      byte_counter <= byte_counter_next;
    end
  end

endmodule

@@ rtl/xdfd_back.sv @@
// ----------------------------------------------------------------------------
// xdfd_back
// Walks positions, writes the frame store and forms one result per command.
// ----------------------------------------------------------------------------
module xdfd_back #(
  parameter int unsigned STORE_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  xdfd_pkg::cmd_t      cmd,
  output logic                cmd_ready,
  input  logic [12:0]         row_width,
  input  logic [12:0]         row_stride,
  input  logic                copy_mode,
  input  logic [16:0]         frame_limit,
  output logic                err,
  output logic                res_valid,
  output xdfd_pkg::out_item_t res
);

  localparam int AW = $clog2(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];
  xdfd_pkg::back_state_t st;
  xdfd_pkg::cmd_t cur;
  logic [AW:0]  clr_addr;
  logic [16:0]  row_base, lin;
  logic [12:0]  column;
  logic [15:0]  remain;
  logic [7:0]   rd_q;
  logic [17:0]  addr_sum, lin_sum, limit_sum;
  logic [12:0]  w_eff;
  logic [13:0]  col_inc;
  logic [13:0]  col_wrap;
  logic [17:0]  base_step;
  logic [16:0]  base_sat;
  logic         oob, over;
  logic         wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]   wr_data;
  logic [13:0]  adv_n;

  assign w_eff = (row_width == 13'd0) ? 13'd1 : row_width;
  assign addr_sum = {1'b0, row_base} + {5'd0, column};
  assign oob = 32'(addr_sum) >= STORE_BYTES;
  assign limit_sum = {1'b0, lin} + {2'd0, cur.count};
  assign over = (frame_limit != 17'd0) && (limit_sum > {1'b0, frame_limit});
  // skips advance by up to one row per cycle, writes by one pixel
  assign adv_n = (cur.kind != xdfd_pkg::CMD_ADVANCE) ? 14'd1 :
                 (remain > 16'(w_eff)) ? {1'b0, w_eff} : remain[13:0];
  assign col_inc = {1'b0, column} + adv_n;
  assign col_wrap = col_inc - {1'b0, w_eff};
  assign base_step = {1'b0, row_base} + {5'd0, row_stride};
  assign base_sat = base_step[17] ? xdfd_pkg::POS_MAX : base_step[16:0];
  assign lin_sum = {1'b0, lin} + {4'd0, adv_n};
  assign cmd_ready = (st == xdfd_pkg::BK_IDLE);
  assign wr_addr = AW'(addr_sum);

  assign rd_addr = (cur.kind == xdfd_pkg::CMD_READ) ? AW'(cur.addr) : wr_addr;
  assign wr_data = (st == xdfd_pkg::BK_CLEAR) ? 8'd0 :
                   (copy_mode == xdfd_pkg::DO_XOR) ? (rd_q ^ cur.value) : cur.value;
  assign wr_en = (st == xdfd_pkg::BK_CLEAR) ||
                 (st == xdfd_pkg::BK_WRITE && cur.kind != xdfd_pkg::CMD_ADVANCE &&
                  remain != 16'd0 && !oob);

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) mem[(st == xdfd_pkg::BK_CLEAR) ? clr_addr[AW-1:0] : wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= xdfd_pkg::BK_CLEAR;
      clr_addr <= '0;
      err <= 1'b0;
      row_base <= '0;
      column <= '0;
      lin <= '0;
      remain <= '0;
      res_valid <= 1'b0;
      res <= '0;
      cur <= '0;
    end else begin
      res_valid <= 1'b0;
      unique case (st)
        xdfd_pkg::BK_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (AW+1)'(STORE_BYTES - 1)) st <= xdfd_pkg::BK_IDLE;
        end
        xdfd_pkg::BK_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            remain <= cmd.count;
            st <= xdfd_pkg::BK_ADV;
          end
        end
        xdfd_pkg::BK_ADV: begin
          st <= xdfd_pkg::BK_DONE;
          unique case (cur.kind)
            xdfd_pkg::CMD_RESTART: begin
              err <= 1'b0; row_base <= '0; column <= '0; lin <= '0;
            end
            xdfd_pkg::CMD_END: begin
              row_base <= '0; column <= '0; lin <= '0;
            end
            xdfd_pkg::CMD_READ: st <= xdfd_pkg::BK_READ;
            xdfd_pkg::CMD_ADVANCE: begin
              if (over) err <= 1'b1;
              else st <= xdfd_pkg::BK_RMW;
            end
            xdfd_pkg::CMD_WRITE: st <= xdfd_pkg::BK_RMW;
            xdfd_pkg::CMD_RUN: begin
              if (over) err <= 1'b1;
              else if (remain != 16'd0) st <= xdfd_pkg::BK_RMW;
            end
            xdfd_pkg::CMD_CHECK: begin
              if (over) err <= 1'b1;
            end
            default: st <= xdfd_pkg::BK_DONE;
          endcase
        end
        xdfd_pkg::BK_RMW: begin
          // wait here for the store read to land
          st <= xdfd_pkg::BK_WRITE;
        end
        xdfd_pkg::BK_WRITE: begin
          if (remain == 16'd0) begin
            st <= xdfd_pkg::BK_DONE;
          end else if (cur.kind != xdfd_pkg::CMD_ADVANCE && oob) begin
            err <= 1'b1;
            st <= xdfd_pkg::BK_DONE;
          end else begin
            if (col_inc >= {1'b0, w_eff}) begin
              column <= col_wrap[12:0];
              row_base <= base_sat;
            end else begin
              column <= col_inc[12:0];
            end
            lin <= lin_sum[17] ? xdfd_pkg::POS_MAX : lin_sum[16:0];
            remain <= remain - 16'(adv_n);
            // column still past a lowered row width: wrap the remaining rows
            if (col_inc >= {1'b0, w_eff} && col_wrap >= {1'b0, w_eff})
              st <= xdfd_pkg::BK_NORM;
            else if (cur.kind != xdfd_pkg::CMD_ADVANCE)
              st <= (remain == 16'(adv_n)) ? xdfd_pkg::BK_DONE : xdfd_pkg::BK_RMW;
          end
        end
        xdfd_pkg::BK_NORM: begin
          if (column >= w_eff) begin
            column <= column - w_eff;
            row_base <= base_sat;
          end else if (remain == 16'd0) begin
            st <= xdfd_pkg::BK_DONE;
          end else if (cur.kind == xdfd_pkg::CMD_ADVANCE) begin
            st <= xdfd_pkg::BK_WRITE;
          end else begin
            st <= xdfd_pkg::BK_RMW;
          end
        end
        xdfd_pkg::BK_READ: st <= xdfd_pkg::BK_DONE;
        xdfd_pkg::BK_DONE: begin
          st <= xdfd_pkg::BK_IDLE;
          res_valid <= 1'b1;
          if (cur.kind == xdfd_pkg::CMD_READ && (32'(cur.addr) < STORE_BYTES))
            res.read_data <= rd_q;
          else
            res.read_data <= 8'd0;
          if (err) begin
            res.status <= xdfd_pkg::ST_ERROR; res.bytes_used <= '0;
          end else if (cur.kind == xdfd_pkg::CMD_END) begin
            res.status <= xdfd_pkg::ST_END; res.bytes_used <= cur.used;
          end else begin
            res.status <= xdfd_pkg::ST_OK; res.bytes_used <= '0;
          end
        end
        default: st <= xdfd_pkg::BK_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/xor_delta_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// xor_delta_frame_decoder_unit
// XOR-delta stream decoder editing an internal frame store.
// ----------------------------------------------------------------------------
// steps: each item passes the queue, then the ADV and DONE states; a read adds READ
// a dump byte adds RMW and WRITE, a run repeats RMW and WRITE per pixel, a skip steps WRITE by up to one row width
// a column left past a lowered row width is wrapped one row at a time in the NORM state
// flow: one item in flight; the next item can be accepted while result_valid is high for the last one
// reset: a clearing pass over all FRAME_STORE_BYTES store bytes runs first, busy stays high
// results last one cycle with result_valid; the receiver cannot stall
module xor_delta_frame_decoder_unit #(
  parameter int unsigned FRAME_STORE_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  xdfd_pkg::in_item_t  in_item,
  output logic                result_valid,
  output xdfd_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_data
);

  logic [12:0] row_width, row_stride;
  logic        copy_mode;
  logic [16:0] frame_limit;
  logic        take, err, q_valid, cmd_ready;
  xdfd_pkg::cmd_t cmd, q_cmd;

  assign cfg_ready = 1'b1;
  assign take = start && !busy;
  assign busy = q_valid || !cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= 13'd320;
      row_stride <= 13'd320;
      copy_mode <= 1'b0;
      frame_limit <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        xdfd_pkg::REG_ROW_WIDTH:   row_width <= cfg_data[12:0];
        xdfd_pkg::REG_ROW_STRIDE:  row_stride <= cfg_data[12:0];
        xdfd_pkg::REG_COPY_MODE:   copy_mode <= cfg_data[0];
        xdfd_pkg::REG_FRAME_LIMIT: frame_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // one-entry queue between parser and executor
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (take) begin
      q_valid <= 1'b1;
      q_cmd <= cmd;
    end else if (q_valid && cmd_ready) begin
      q_valid <= 1'b0;
    end
  end

  xdfd_front u_front (
    .clk(clk), .rst(rst), .take(take), .item(in_item), .err(err), .cmd(cmd)
  );

  xdfd_back #(.STORE_BYTES(FRAME_STORE_BYTES)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd(q_cmd), .cmd_ready(cmd_ready),
    .row_width(row_width), .row_stride(row_stride), .copy_mode(copy_mode),
    .frame_limit(frame_limit), .err(err),
    .res_valid(result_valid), .res(result)
  );

endmodule

@@ tb/sv/xor_delta_frame_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// xor_delta_frame_decoder_unit_tb
// Drives delta streams, pixel reads and restarts into the frame decoder under
// several row layouts, copy modes and frame limits, predicts every result with
// a behavioral copy of the decoder and its frame store, and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_delta_frame_decoder_unit_tb;

  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned STALL_LIMIT = 300000;

  class frame_scoreboard;
    byte unsigned pixels[STORE_BYTES];
    xdfd_pkg::phase_t phase;
    int unsigned op_left, word_lo, row_base, column, lin_pos, byte_count;
    bit          in_error;
    int unsigned width_reg, stride_reg, limit_reg;
    bit          copy_reg;
    xdfd_pkg::out_item_t pending[$];
    int          mismatches;

    function void rewind();
      row_base = 0; column = 0; lin_pos = 0; byte_count = 0;
      phase = xdfd_pkg::PH_OPCODE; op_left = 0; word_lo = 0;
    endfunction

    function void clear();
      foreach (pixels[i]) pixels[i] = 0;
      rewind();
      in_error = 0; width_reg = 320; stride_reg = 320; copy_reg = 0; limit_reg = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        xdfd_pkg::REG_ROW_WIDTH:   width_reg = val[12:0];
        xdfd_pkg::REG_ROW_STRIDE:  stride_reg = val[12:0];
        xdfd_pkg::REG_COPY_MODE:   copy_reg = val[0];
        xdfd_pkg::REG_FRAME_LIMIT: limit_reg = val;
        default: ;
      endcase
    endfunction

    function bit past_limit(int unsigned n);
      if (limit_reg != 0 && lin_pos + n > limit_reg) begin
        in_error = 1;
        return 1;
      end
      return 0;
    endfunction

    function void move_on(int unsigned n);
      int unsigned w, total;
      longint unsigned nb;
      w = (width_reg == 0) ? 1 : width_reg;
      total = column + n;
      nb = longint'(total / w) * stride_reg + row_base;
      column = total % w;
      row_base = (nb > xdfd_pkg::POS_MAX) ? xdfd_pkg::POS_MAX : nb;
      lin_pos = (lin_pos + n > xdfd_pkg::POS_MAX) ? xdfd_pkg::POS_MAX : lin_pos + n;
    endfunction

    function bit put_pixel(byte unsigned v);
      int unsigned a;
      a = row_base + column;
      if (a >= STORE_BYTES) begin
        in_error = 1;
        return 0;
      end
      pixels[a] = (copy_reg == xdfd_pkg::DO_XOR) ? (pixels[a] ^ v) : v;
      move_on(1);
      return 1;
    endfunction

    function void fill(int unsigned n, byte unsigned v);
      if (past_limit(n)) return;
      for (int unsigned i = 0; i < n; i++)
        if (!put_pixel(v)) return;
    endfunction

    // returns 1 when the end code completes the frame
    function bit take_byte(byte unsigned b);
      int unsigned w;
      if (byte_count < 16'hFFFF) byte_count++;
      case (phase)
        xdfd_pkg::PH_OPCODE: begin
          if (b == 0) phase = xdfd_pkg::PH_SRUN_COUNT;
          else if (b < xdfd_pkg::WORD_ESCAPE) begin
            if (!past_limit(b)) begin
              op_left = b;
              phase = xdfd_pkg::PH_DUMP;
            end
          end else if (b == xdfd_pkg::WORD_ESCAPE) phase = xdfd_pkg::PH_WORD_LO;
          else if (!past_limit(b - xdfd_pkg::WORD_ESCAPE)) move_on(b - xdfd_pkg::WORD_ESCAPE);
        end
        xdfd_pkg::PH_SRUN_COUNT: begin
          op_left = b;
          phase = xdfd_pkg::PH_SRUN_VALUE;
        end
        xdfd_pkg::PH_SRUN_VALUE, xdfd_pkg::PH_LRUN_VALUE: begin
          phase = xdfd_pkg::PH_OPCODE;
          fill(op_left, b);
        end
        xdfd_pkg::PH_WORD_LO: begin
          word_lo = b;
          phase = xdfd_pkg::PH_WORD_HI;
        end
        xdfd_pkg::PH_WORD_HI: begin
          w = word_lo | (int'(b) << 8);
          phase = xdfd_pkg::PH_OPCODE;
          if (w == 0) return 1;
          if (w < 'h8000) begin
            if (!past_limit(w)) move_on(w);
          end else if (((w - 'h8000) & 'h4000) == 0) begin
            op_left = w - 'h8000;
            if (!past_limit(op_left) && op_left != 0) phase = xdfd_pkg::PH_DUMP;
          end else begin
            op_left = w - 'hC000;
            phase = xdfd_pkg::PH_LRUN_VALUE;
          end
        end
        xdfd_pkg::PH_DUMP: begin
          if (put_pixel(b)) begin
            op_left = (op_left - 1) & 'h7FFF;
            if (op_left == 0) phase = xdfd_pkg::PH_OPCODE;
          end
        end
        default: phase = xdfd_pkg::PH_OPCODE;
      endcase
      return 0;
    endfunction

    function void note_input(xdfd_pkg::in_item_t it);
      xdfd_pkg::out_item_t r;
      r = '0;
      case (it.action)
        xdfd_pkg::ACT_DELTA: begin
          if (!in_error && take_byte(it.delta_byte) && !in_error) begin
            r.status = xdfd_pkg::ST_END;
            r.bytes_used = byte_count;
            rewind();
          end
        end
        xdfd_pkg::ACT_READ: r.read_data = pixels[it.read_address];
        xdfd_pkg::ACT_RESTART: begin
          rewind();
          in_error = 0;
        end
        default: ;
      endcase
      if (in_error) begin
        r.status = xdfd_pkg::ST_ERROR;
        r.bytes_used = 0;
      end
      pending.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_result(xdfd_pkg::out_item_t got);
      xdfd_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report("result with nothing outstanding, status", got.status, 0);
        return;
      end
      want = pending.pop_front();
      if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.bytes_used !== want.bytes_used)
        report("bytes_used", got.bytes_used, want.bytes_used);
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  xdfd_pkg::in_item_t in_item = '0;
  logic        result_valid;
  xdfd_pkg::out_item_t result;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  frame_scoreboard frames;
  int          idle_pct;
  int unsigned stall_cycles;
  xdfd_pkg::in_item_t stream[$];

  xor_delta_frame_decoder_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && frames != null && result_valid) frames.check_result(result);
  end

  // counts cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task send_item(xdfd_pkg::in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_item <= it;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    frames.note_input(it);
  endtask

  task wait_drained();
    start <= 0;
    @(posedge clk);
    while (frames.pending.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task cfg_write(logic [1:0] idx, logic [16:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    frames.set_reg(idx, val);
  endtask

  task configure(int w, int s, bit m, int lim);
    cfg_write(xdfd_pkg::REG_ROW_WIDTH, 17'(w));
    cfg_write(xdfd_pkg::REG_ROW_STRIDE, 17'(s));
    cfg_write(xdfd_pkg::REG_COPY_MODE, 17'(m));
    cfg_write(xdfd_pkg::REG_FRAME_LIMIT, 17'(lim));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function xdfd_pkg::in_item_t delta(byte unsigned b);
    xdfd_pkg::in_item_t it;
    it = '0;
    it.action = xdfd_pkg::ACT_DELTA;
    it.delta_byte = b;
    it.read_address = $urandom;
    return it;
  endfunction

  function xdfd_pkg::in_item_t other(logic [1:0] act, logic [15:0] a);
    xdfd_pkg::in_item_t it;
    it = '0;
    it.action = act;
    it.delta_byte = $urandom;
    it.read_address = a;
    return it;
  endfunction

  task push_word(int unsigned w);
    stream.push_back(delta(xdfd_pkg::WORD_ESCAPE));
    stream.push_back(delta(w[7:0]));
    stream.push_back(delta(w[15:8]));
  endtask

  // one well-formed frame of small operations, with some noise mixed in
  task build_frame();
    int unsigned n;
    if ($urandom_range(99) < 30) stream.push_back(other(xdfd_pkg::ACT_RESTART, $urandom));
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(9))
        0, 1: begin
          n = $urandom_range(1, 8);
          if ($urandom_range(19) == 0) n = 127;
          stream.push_back(delta(n));
          repeat (n) stream.push_back(delta($urandom));
        end
        2: begin
          stream.push_back(delta(0));
          stream.push_back(delta($urandom_range(0, 20)));
          stream.push_back(delta($urandom));
        end
        3: stream.push_back(delta($urandom_range(0, 3) == 0 ? $urandom_range(129, 255)
                                                            : $urandom_range(129, 150)));
        4: push_word($urandom_range(1, 300));
        5: begin
          n = $urandom_range(0, 10);
          push_word('h8000 + n);
          repeat (n) stream.push_back(delta($urandom));
        end
        6: begin
          push_word('hC000 + $urandom_range(0, 30));
          stream.push_back(delta($urandom));
        end
        7: stream.push_back(other(xdfd_pkg::ACT_READ, $urandom_range(0, 3) == 0 ? $urandom
                                                          : $urandom_range(0, 2047)));
        8: stream.push_back(other($urandom_range(0, 1) ? xdfd_pkg::ACT_IDLE
                                                      : xdfd_pkg::ACT_DELTA, $urandom));
        default: stream.push_back(delta($urandom));
      endcase
    end
    push_word(0);
    repeat ($urandom_range(0, 2))
      stream.push_back(other(xdfd_pkg::ACT_READ, $urandom_range(0, 2047)));
  endtask

  task run_random(int count);
    stream.delete();
    while (stream.size() < count) build_frame();
    foreach (stream[i]) send_item(stream[i]);
  endtask

  initial begin
    frames = new();
    frames.clear();
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: every opcode, reads at the store extremes, restart and idle
    configure(16, 20, 0, 0);
    stream.delete();
    stream.push_back(delta(2)); stream.push_back(delta(8'hFF)); stream.push_back(delta(8'h00));
    stream.push_back(delta(0)); stream.push_back(delta(3)); stream.push_back(delta(8'hAA));
    stream.push_back(delta(8'h81)); stream.push_back(delta(8'hFF));
    push_word(5);
    push_word('h8002); stream.push_back(delta(8'h5A)); stream.push_back(delta(8'hA5));
    push_word('hC003); stream.push_back(delta(8'h3C));
    push_word(0);
    stream.push_back(other(xdfd_pkg::ACT_READ, 0));
    stream.push_back(other(xdfd_pkg::ACT_READ, 16'hFFFF));
    stream.push_back(other(xdfd_pkg::ACT_IDLE, 0));
    stream.push_back(delta(1));
    stream.push_back(other(xdfd_pkg::ACT_RESTART, 0));
    foreach (stream[i]) send_item(stream[i]);
    wait_drained();

    // store end: linear full-width rows, then skip past the end of the store and dump
    configure(4096, 4096, 1, 0);
    stream.delete();
    push_word('h7FFF); push_word('h7FFF); push_word('h0002);
    stream.push_back(delta(2)); stream.push_back(delta(8'h11)); stream.push_back(delta(8'h22));
    stream.push_back(other(xdfd_pkg::ACT_READ, 16'hFFFF));
    stream.push_back(other(xdfd_pkg::ACT_RESTART, 0));
    push_word('hFFFF); stream.push_back(delta(8'h77));
    stream.push_back(other(xdfd_pkg::ACT_RESTART, 0));
    foreach (stream[i]) send_item(stream[i]);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: configure(16, 20, 0, 0);
        1: configure(1, 1, 1, 65536);
        2: configure(4096, 1, 0, 0);
        3: configure($urandom_range(1, 64), $urandom_range(1, 128), $urandom_range(0, 1),
                     $urandom_range(50, 400));
        4: configure(7, 4096, 0, 0);
        5: configure($urandom_range(1, 4096), $urandom_range(1, 4096), 1,
                     $urandom_range(0, 65536));
        default: configure(320, 320, $urandom_range(0, 1), 0);
      endcase
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 76;
        2: idle_pct = 0;
        default: idle_pct = 32;
      endcase
      run_random(85);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (frames.mismatches == 0 && frames.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
